// ----- hdl/u8dec_pkg.sv -----
package u8dec_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POINT_W = 21;
    localparam int unsigned PEND_W  = 2;
    localparam int unsigned CONT_W  = 6;   // payload bits of a following byte
    localparam int unsigned TDATA_W = 24;  // code point padded to whole bytes

    // Following bytes expected after each kind of lead
    localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
    localparam logic [PEND_W-1:0] PEND_LEAD2 = 2'd1;
    localparam logic [PEND_W-1:0] PEND_LEAD3 = 2'd2;
    localparam logic [PEND_W-1:0] PEND_LEAD4 = 2'd3;

    typedef struct packed {
        logic [PEND_W-1:0]  pending;
        logic [POINT_W-1:0] partial;
    } t_dec_state;

    typedef struct packed {
        logic               emit;
        logic [POINT_W-1:0] code_point;
        logic               point_valid;
        logic               string_done;
    } t_dec_res;

endpackage

// ----- hdl/u8dec_step.sv -----
module u8dec_step
    import u8dec_pkg::*;
(
    input  t_dec_state        i_state,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    output t_dec_state        o_state,
    output t_dec_res          o_res
);

    logic [POINT_W-1:0] shifted;
    logic [PEND_W-1:0]  pend_dec;
    logic               have_point;
    logic [POINT_W-1:0] point;
    t_dec_state         nxt;

    assign shifted  = {i_state.partial[POINT_W-CONT_W-1:0], i_byte[CONT_W-1:0]};
    assign pend_dec = i_state.pending - PEND_W'(1);

    always_comb begin
        nxt        = i_state;
        have_point = 1'b0;
        point      = '0;
        if (i_state.pending == PEND_NONE) begin
            unique casez (i_byte)
                8'b0???????: begin
                    point      = POINT_W'(i_byte);
                    have_point = 1'b1;
                end
                8'b10??????: begin
                    // stray continuation: drop
                end
                8'b110?????: begin
                    nxt.partial = POINT_W'(i_byte[4:0]);
                    nxt.pending = PEND_LEAD2;
                end
                8'b1110????: begin
                    nxt.partial = POINT_W'(i_byte[3:0]);
                    nxt.pending = PEND_LEAD3;
                end
                default: begin
                    // 0xF0 and up, long leads included
                    nxt.partial = POINT_W'(i_byte[2:0]);
                    nxt.pending = PEND_LEAD4;
                end
            endcase
        end else begin
            nxt.partial = shifted;
            nxt.pending = pend_dec;
            if (pend_dec == PEND_NONE) begin
                point       = shifted;
                have_point  = 1'b1;
                nxt.partial = '0;
            end
        end
        // end of string discards any open sequence
        if (i_last) begin
            nxt = '0;
        end
    end

    assign o_state           = nxt;
    assign o_res.emit        = have_point | i_last;
    assign o_res.code_point  = point;
    assign o_res.point_valid = have_point;
    assign o_res.string_done = i_last;

endmodule

// ----- hdl/utf8_to_utf32_decoder.sv -----
// A result is registered and appears on the master side in the cycle after its byte beat is taken.
// Throughput: one byte beat per cycle, sustained; a beat is taken whenever the
// result register is empty or is being drained in the same cycle.
// Reset: synchronous, active low; clears the open sequence and the result valid flag.
module utf8_to_utf32_decoder
    import u8dec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic               s_axis_tlast,   // end_of_string
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic               m_axis_tuser,   // [0] point_valid
    output logic               m_axis_tlast    // string_done
);

    // Decoder state: following bytes still owed and the bits gathered so far
    t_dec_state r_state;
    t_dec_state n_state;

    // Result register; it holds each result for the consumer, and a beat is taken
    // only while it is empty or is being drained in the same cycle
    logic       r_out_valid;
    logic       n_out_valid;
    t_dec_res   r_out;
    t_dec_res   step_res;

    logic       in_beat;
    logic       out_beat;

    assign out_beat      = r_out_valid & m_axis_tready;
    assign s_axis_tready = ~r_out_valid | m_axis_tready;
    assign in_beat       = s_axis_tvalid & s_axis_tready;

    u8dec_step u_step (
        .i_state (r_state),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_state (n_state),
        .o_res   (step_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_beat) begin
            n_out_valid = 1'b0;
        end
        // a beat that completes a character or ends the string loads a result
        if (in_beat && step_res.emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_beat) begin
                r_state <= n_state;
            end
        end
    end

    // Payload: load only; no reset needed
    always_ff @(posedge i_clk) begin
        if (in_beat && step_res.emit) begin
            r_out <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out.code_point);
    assign m_axis_tuser  = r_out.point_valid;
    assign m_axis_tlast  = r_out.string_done;

`ifndef SYNTH
    // A full result register that is not drained stalls the input side
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while result register is blocked");

    // The last byte of a string always leaves a result with string_done
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && s_axis_tlast |=> r_out_valid && m_axis_tlast)
        else $error("end of string produced no end marker");

    // The last byte of a string discards any open sequence
    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && s_axis_tlast |=> r_state.pending == PEND_NONE && r_state.partial == '0)
        else $error("sequence state survived end of string");

    // A result without a character is a bare end marker with a zero point
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.point_valid |-> r_out.string_done && r_out.code_point == '0)
        else $error("result without character or end marker");
`endif

endmodule

// ----- test/utf8_to_utf32_decoder_test.sv -----
`timescale 1ns / 1ps

import u8dec_pkg::*;

// One expected beat on the master side
typedef struct packed {
    logic [POINT_W-1:0] code_point;
    logic               point_valid;
    logic               string_done;
} t_point_exp;

// Track the decoder state from the accepted bytes and hold the code points still owed
class u8_point_predictor;
    logic [PEND_W-1:0]  pending;
    logic [POINT_W-1:0] partial;
    t_point_exp         expected_points[$];
    int unsigned        errors;

    function new();
        pending = PEND_NONE;
        partial = '0;
        errors  = 0;
    endfunction

    // Advance the state by one accepted byte and queue the result it causes, if any
    function void take_byte(logic [BYTE_W-1:0] value, logic last);
        t_point_exp res;
        logic       complete;
        res      = '0;
        complete = 1'b0;
        if (pending == PEND_NONE) begin
            if (!value[7]) begin
                res.code_point = POINT_W'(value);
                complete       = 1'b1;
            end else if (value[7:6] == 2'b10) begin
                // stray continuation in lead position: drop it
            end else if (value[7:5] == 3'b110) begin
                partial = POINT_W'(value[4:0]);
                pending = PEND_LEAD2;
            end else if (value[7:4] == 4'b1110) begin
                partial = POINT_W'(value[3:0]);
                pending = PEND_LEAD3;
            end else begin
                // 0xF0 and up, long leads included, keep three payload bits
                partial = POINT_W'(value[2:0]);
                pending = PEND_LEAD4;
            end
        end else begin
            // follower taken blindly, whatever its top bits
            partial = {partial[POINT_W-CONT_W-1:0], value[CONT_W-1:0]};
            pending = pending - PEND_W'(1);
            if (pending == PEND_NONE) begin
                res.code_point = partial;
                complete       = 1'b1;
                partial        = '0;
            end
        end
        // end of string discards any open sequence
        if (last) begin
            pending = PEND_NONE;
            partial = '0;
        end
        res.point_valid = complete;
        res.string_done = last;
        if (complete || last)
            expected_points.push_back(res);
    endfunction

    // Compare one accepted result beat with the oldest expectation
    function void check_point(logic [TDATA_W-1:0] tdata, logic tuser, logic tlast);
        t_point_exp want;
        if (expected_points.size() == 0) begin
            $display("%0t: result with nothing expected: tdata=%h tuser=%b tlast=%b",
                     $time, tdata, tuser, tlast);
            errors++;
            return;
        end
        want = expected_points.pop_front();
        if (tdata !== TDATA_W'(want.code_point) || tuser !== want.point_valid
                || tlast !== want.string_done) begin
            $display({"%0t: mismatch: expected tdata=%h tuser=%b tlast=%b, ",
                      "got tdata=%h tuser=%b tlast=%b"},
                     $time, TDATA_W'(want.code_point), want.point_valid, want.string_done,
                     tdata, tuser, tlast);
            errors++;
        end
    endfunction
endclass

module utf8_to_utf32_decoder_test;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_BYTES  = 330;

    // Directed bytes: bit 8 marks the last byte of a string
    localparam logic [8:0] DIRECTED [24] = '{
        9'h000, 9'h07F,                  // ASCII extremes
        9'h080,                          // stray continuation, no result
        9'h1BF,                          // stray continuation as last byte: bare end marker
        9'h0C2, 9'h0A9,                  // two-byte sequence
        9'h0DF, 9'h0BF,                  // highest two-byte lead and follower
        9'h0E2, 9'h082, 9'h0AC,          // three-byte sequence
        9'h0F0, 9'h09F, 9'h098, 9'h080,  // four-byte sequence
        9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,  // long lead, completes on the last byte
        9'h0E0, 9'h141,                  // sequence cut short by end of string
        9'h0C0, 9'h041,                  // ASCII byte swallowed as a follower
        9'h141                           // ASCII as last byte
    };

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [BYTE_W-1:0]  s_axis_tdata  = '0;
    logic               s_axis_tlast  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tlast;

    int unsigned        send_idle_pct = 0;
    int unsigned        recv_stall_pct = 0;
    int unsigned        bytes_sent = 0;
    int unsigned        cycle_count = 0;
    logic [BYTE_W-1:0]  string_bytes[$];

    u8_point_predictor  decoded_points = new();

    utf8_to_utf32_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] byte_in
        .s_axis_tlast  (s_axis_tlast),   // end_of_string
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [20:0] code_point, [23:21] zero
        .m_axis_tuser  (m_axis_tuser),   // [0] point_valid
        .m_axis_tlast  (m_axis_tlast)    // string_done
    );

    initial forever #1 i_clk = ~i_clk;

    // Stall the result side at random
    initial forever begin
        @(negedge i_clk);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every result beat taken
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            decoded_points.check_point(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("utf8_to_utf32_decoder_test: done, errors");
            $finish;
        end
    end

    // Present one byte beat, called and returning at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        decoded_points.take_byte(value, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Build a mostly well-formed string with random content, then send it
    task automatic send_random_string();
        int unsigned chars;
        int unsigned pick;
        int unsigned followers;
        string_bytes.delete();
        chars = $urandom_range(12, 1);
        repeat (chars) begin
            pick = $urandom_range(99);
            followers = 0;
            if (pick < 45) begin
                string_bytes.push_back({1'b0, 7'($urandom_range(127))});
            end else if (pick < 65) begin
                string_bytes.push_back({3'b110, 5'($urandom_range(31))});
                followers = 1;
            end else if (pick < 80) begin
                string_bytes.push_back({4'b1110, 4'($urandom_range(15))});
                followers = 2;
            end else if (pick < 92) begin
                // low four bits random, so long leads show up too
                string_bytes.push_back({4'b1111, 4'($urandom_range(15))});
                followers = 3;
            end else begin
                string_bytes.push_back(8'($urandom_range(255)));
            end
            // now and then cut a sequence short so the next char gets swallowed
            if (followers > 0 && $urandom_range(15) == 0)
                followers--;
            repeat (followers) begin
                if ($urandom_range(19) == 0)
                    string_bytes.push_back(8'($urandom_range(255)));
                else
                    string_bytes.push_back({2'b10, 6'($urandom_range(63))});
            end
        end
        // sometimes drop the last byte, which can end the string in the middle of a sequence
        if (string_bytes.size() > 1 && $urandom_range(9) == 0)
            void'(string_bytes.pop_back());
        foreach (string_bytes[i])
            send_byte(string_bytes[i], i == string_bytes.size() - 1);
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target)
            send_random_string();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

        run_phase(0, 0);
        run_phase(75, 0);
        run_phase(0, 75);
        run_phase(35, 35);
        s_axis_tvalid <= 1'b0;

        // drain, then give the output register time to show anything extra
        while (decoded_points.expected_points.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (decoded_points.errors == 0)
            $display("utf8_to_utf32_decoder_test: done, clean");
        else
            $display("utf8_to_utf32_decoder_test: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/u8dec_pkg.sv
hdl/u8dec_step.sv
hdl/utf8_to_utf32_decoder.sv
test/utf8_to_utf32_decoder_test.sv
